// ----- src/bui_pkg.sv -----
// Shared widths, register indexes and divider request/response types for the
// bilinear integer upsampler. No dependencies.
`default_nettype none

package bui_pkg;

  localparam int COARSE_DIM_DEF = 128;
  localparam int MAX_FACTOR_DEF = 16;

  localparam int IDX_W   = 11;
  localparam int SMP_W   = 32;
  localparam int FW      = 5;
  localparam int WGT_W   = 2 * FW;
  localparam int SUM_W   = 44;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Z = 2'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [SUM_W-1:0]  dividend;
    logic [WGT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [WGT_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/bui_div.sv -----
// Shared restoring divider, one quotient bit per cycle, for a chosen number of
// steps taken from the top of the dividend. Depends on bui_pkg.
`default_nettype none

module bui_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bui_pkg::div_req_t req,
  output bui_pkg::div_rsp_t      rsp
);
  import bui_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [SUM_W-1:0]  q;
  logic [WGT_W-1:0]  r;
  logic [WGT_W-1:0]  d;
  logic [WGT_W:0]    trial;
  logic              fits;

  assign trial = {r, q[SUM_W-1]};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
      q    <= req.dividend;
      r    <= '0;
      d    <= req.divisor;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - STEP_W'(1);
        q   <= {q[SUM_W-2:0], fits};
        r   <= fits ? WGT_W'(trial - {1'b0, d}) : trial[WGT_W-1:0];
      end
    end
  end

  assign rsp.done = busy && (cnt == '0);
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

`default_nettype wire

// ----- src/bilinear_integer_upsampler_top.sv -----
// Top level of the bilinear integer upsampler: coarse sample store, query
// sequencer and output register. Depends on bui_pkg and bui_div.
//
// A load beat writes its sample to the store when both indexes lie in the grid.
// A query beat runs in order: the shared divider splits x_index and z_index,
// four neighbour taps each pass through the single-port store (read, multiply,
// accumulate), and the final divide is by factor_x * factor_z. The result then
// moves into the output register once that register is free or being taken,
// and the next beat is accepted when the sequencer is back in idle. in_ready
// is low while a query runs; a finished result waits in the output register
// while the next beat is accepted. The store is not cleared after reset; read
// only written entries.
`default_nettype none

module bilinear_integer_upsampler_top #(
  parameter int COARSE_DIM = bui_pkg::COARSE_DIM_DEF,
  parameter int MAX_FACTOR = bui_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           func,
  input  wire logic [bui_pkg::IDX_W-1:0]      x_index,
  input  wire logic [bui_pkg::IDX_W-1:0]      z_index,
  input  wire logic signed [bui_pkg::SMP_W-1:0] sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [bui_pkg::SMP_W-1:0]    value,
  output logic                                outside,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bui_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bui_pkg::FW-1:0]         cfg_data
);
  import bui_pkg::*;

  localparam int DEPTH     = COARSE_DIM * COARSE_DIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int FMAX      = (1 << FW) - 1;
  localparam int MAXF_CLIP = (MAX_FACTOR > FMAX) ? FMAX : MAX_FACTOR;

  typedef enum logic [2:0] {
    S_IDLE, S_DIVX, S_DIVZ, S_TAP, S_MUL, S_ACC, S_DIVQ, S_FIN
  } state_t;

  state_t state;

  logic [FW-1:0] factor_x;
  logic [FW-1:0] factor_z;
  logic [FW-1:0] fx_eff;
  logic [FW-1:0] fz_eff;

  logic [FW-1:0]    fx;
  logic [FW-1:0]    fz;
  logic [WGT_W-1:0] fxz;
  logic [IDX_W-1:0] ix;
  logic [IDX_W-1:0] iz;
  logic [FW-1:0]    rx;
  logic [FW-1:0]    rz;
  logic [1:0]       k;
  logic             beyond;
  logic             tap_hit;
  logic [WGT_W-1:0] tap_wr;
  logic signed [SUM_W-1:0] prod;
  logic signed [SUM_W-1:0] acc;
  logic signed [SMP_W-1:0] qv;

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_acc;
  logic              load_ok;
  logic              wr_en;
  logic              rd_en;
  logic              div_start_next;
  logic [AW-1:0]     load_addr;
  logic [AW-1:0]     tap_addr;
  logic [AW-1:0]     mem_addr;
  logic [IDX_W:0]    tap_col;
  logic [IDX_W:0]    tap_row;
  logic [FW-1:0]     xw;
  logic [FW-1:0]     zw;
  logic [WGT_W-1:0]  tap_w;
  logic              tap_in;
  logic              acc_neg;
  logic [SUM_W-1:0]  acc_mag;
  logic signed [SUM_W-1:0] acc_next;

  bui_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (factor_x == '0) begin
      fx_eff = FW'(1);
    end else if (factor_x > FW'(MAXF_CLIP)) begin
      fx_eff = FW'(MAXF_CLIP);
    end else begin
      fx_eff = factor_x;
    end
    if (factor_z == '0) begin
      fz_eff = FW'(1);
    end else if (factor_z > FW'(MAXF_CLIP)) begin
      fz_eff = FW'(MAXF_CLIP);
    end else begin
      fz_eff = factor_z;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_x <= FW'(1);
      factor_z <= FW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FACTOR_X: factor_x <= cfg_data;
        REG_FACTOR_Z: factor_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // tap k: bit 0 low selects column ix+1, bit 1 low selects row iz+1
  always_comb begin
    tap_col  = {1'b0, ix} + (IDX_W + 1)'(!k[0]);
    tap_row  = {1'b0, iz} + (IDX_W + 1)'(!k[1]);
    xw       = k[0] ? FW'(fx - rx) : rx;
    zw       = k[1] ? FW'(fz - rz) : rz;
    tap_w    = WGT_W'(xw) * WGT_W'(zw);
    tap_in   = (tap_col < COARSE_DIM) && (tap_row < COARSE_DIM);
    tap_addr = AW'(tap_col * COARSE_DIM) + AW'(tap_row);
  end

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_ok   = (x_index < COARSE_DIM) && (z_index < COARSE_DIM);
  assign load_addr = AW'(x_index * COARSE_DIM) + AW'(z_index);
  assign wr_en     = in_acc && (func == FUNC_LOAD) && load_ok;
  assign rd_en     = (state == S_TAP) && (tap_w != '0) && tap_in;
  assign mem_addr  = (state == S_IDLE) ? load_addr : tap_addr;

  assign div_start_next = ((state == S_IDLE) && in_acc && (func == FUNC_QUERY)) ||
                          ((state == S_DIVX) && div_rsp.done) ||
                          ((state == S_ACC) && (k == 2'd3));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= sample;
    end else if (rd_en) begin
      rdata <= mem[mem_addr];
    end
  end

  assign acc_next = acc + prod;
  assign acc_neg  = acc_next[SUM_W-1];
  assign acc_mag  = acc_neg ? SUM_W'(-acc_next) : SUM_W'(acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= div_start_next;
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (func == FUNC_QUERY)) begin
            fx               <= fx_eff;
            fz               <= fz_eff;
            fxz              <= WGT_W'(fx_eff) * WGT_W'(fz_eff);
            iz               <= z_index;
            div_req.steps    <= STEP_W'(IDX_W);
            div_req.dividend <= {x_index, (SUM_W - IDX_W)'(0)};
            div_req.divisor  <= WGT_W'(fx_eff);
            state            <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            ix               <= div_rsp.quot[IDX_W-1:0];
            rx               <= div_rsp.rem[FW-1:0];
            div_req.steps    <= STEP_W'(IDX_W);
            div_req.dividend <= {iz, (SUM_W - IDX_W)'(0)};
            div_req.divisor  <= WGT_W'(fz);
            state            <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          if (div_rsp.done) begin
            iz     <= div_rsp.quot[IDX_W-1:0];
            rz     <= div_rsp.rem[FW-1:0];
            k      <= 2'd0;
            beyond <= 1'b0;
            acc    <= '0;
            state  <= S_TAP;
          end
        end
        S_TAP: begin
          tap_hit <= rd_en;
          tap_wr  <= tap_w;
          if ((tap_w != '0) && !tap_in) begin
            beyond <= 1'b1;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= tap_hit ? SUM_W'(rdata) * SUM_W'($signed({1'b0, tap_wr})) : SUM_W'(0);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_next;
          k   <= k + 2'd1;
          if (k == 2'd3) begin
            div_req.steps    <= STEP_W'(SUM_W);
            div_req.dividend <= acc_mag;
            div_req.divisor  <= fxz;
            state            <= S_DIVQ;
          end else begin
            state <= S_TAP;
          end
        end
        S_DIVQ: begin
          if (div_rsp.done) begin
            qv    <= acc[SUM_W-1] ? -$signed(div_rsp.quot[SMP_W-1:0])
                                  : $signed(div_rsp.quot[SMP_W-1:0]);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= qv;
            outside   <= beyond;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (tap_col < COARSE_DIM) && (tap_row < COARSE_DIM))
    else $error("store read outside the coarse grid");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVX) || (state == S_DIVZ) || (state == S_DIVQ))
    else $error("divider finished with no waiting step");

  a_rem_below_fx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVX) && div_rsp.done |-> (div_rsp.rem < WGT_W'(fx)))
    else $error("column remainder not below factor");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && (!out_valid || out_ready) |=> out_valid && (state == S_IDLE))
    else $error("finished query not delivered");

endmodule

`default_nettype wire
